>>> rtl/core/bmff_pkg.sv
// bmff_pkg: map geometry, command codes and the word bit search helper
// for the bitmap set/test/find-first core. No dependencies.
package bmff_pkg;

  localparam int MAP_WIDTH     = 1024;
  localparam int MAP_HEIGHT    = 1024;
  localparam int WORD_W        = 32;
  localparam int BIT_AW        = $clog2(WORD_W);
  localparam int WORDS_PER_ROW = (MAP_WIDTH + WORD_W - 1) / WORD_W;
  localparam int WORD_AW       = $clog2(WORDS_PER_ROW);
  localparam int ROW_AW        = $clog2(MAP_HEIGHT);
  localparam int MEM_AW        = ROW_AW + WORD_AW;
  localparam int MEM_DEPTH     = MAP_HEIGHT << WORD_AW;
  localparam int CMD_W         = 3;
  localparam int FIELD_W       = 10;

  localparam logic [CMD_W-1:0] CMD_TEST  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLRALL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND  = 3'd4;

  // Index of the lowest set bit of a non-zero word: halve the window five times.
  function automatic logic [BIT_AW-1:0] ffs32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] w;
    logic [BIT_AW-1:0] idx;
    w   = v;
    idx = '0;
    if (w[15:0] == 16'h0) begin
      idx[4] = 1'b1;
      w      = w >> 16;
    end
    if (w[7:0] == 8'h0) begin
      idx[3] = 1'b1;
      w      = w >> 8;
    end
    if (w[3:0] == 4'h0) begin
      idx[2] = 1'b1;
      w      = w >> 4;
    end
    if (w[1:0] == 2'h0) begin
      idx[1] = 1'b1;
      w      = w >> 2;
    end
    if (w[0] == 1'b0) begin
      idx[0] = 1'b1;
    end
    return idx;
  endfunction

endpackage

>>> rtl/core/bitmap_set_test_find_first_core.sv
// bitmap_set_test_find_first_core: two-dimensional bit map in a word memory
// with separate read and write ports, and with test, set, clear, clear-all and find-first commands.
// Depends on bmff_pkg.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid in_ready in_cmd in_col in_row  | to core
//   out     | out_valid out_ready out_hit             | from core
//           | out_found_col out_found_row             |
//
// Steps per word: test/set/clear inside the map go through accept, memory read,
// and modify and write back; out-of-map positions answer from the read state
// and unused codes at accept. Clear-all takes the accept step and then sweeps
// the memory one word a cycle. Find reads one word a cycle from row 0 upward.
// After reset the core runs the same clearing pass before in_ready rises.
// A result waits in the output register; the next word is taken once it has
// gone.
module bitmap_set_test_find_first_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bmff_pkg::CMD_W-1:0]   in_cmd,
  input  logic [bmff_pkg::FIELD_W-1:0] in_col,
  input  logic [bmff_pkg::FIELD_W-1:0] in_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [bmff_pkg::FIELD_W-1:0] out_found_col,
  output logic [bmff_pkg::FIELD_W-1:0] out_found_row
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_MOD,
    ST_SCAN
  } state_t;

  localparam int MEM_AW  = bmff_pkg::MEM_AW;
  localparam int WORD_AW = bmff_pkg::WORD_AW;
  localparam int ROW_AW  = bmff_pkg::ROW_AW;
  localparam int BIT_AW  = bmff_pkg::BIT_AW;
  localparam int WORD_W  = bmff_pkg::WORD_W;
  localparam int FIELD_W = bmff_pkg::FIELD_W;
  localparam logic [MEM_AW-1:0]  LAST_ADDR = MEM_AW'(bmff_pkg::MEM_DEPTH - 1);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(bmff_pkg::WORDS_PER_ROW - 1);
  localparam logic [ROW_AW-1:0]  LAST_ROW  = ROW_AW'(bmff_pkg::MAP_HEIGHT - 1);

  // Word store; contents are defined by the clearing pass, not by reset.
  logic [WORD_W-1:0] mem [bmff_pkg::MEM_DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  logic              mem_we;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_waddr;
  logic [MEM_AW-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  state_t                      state_r;
  logic [bmff_pkg::CMD_W-1:0]  cmd_r;
  logic [FIELD_W-1:0]          col_r;
  logic [FIELD_W-1:0]          row_r;
  logic                        clr_reply_r;   // clear sweep answers a clear-all word
  logic [MEM_AW-1:0]           clr_addr_r;

  // Find scan: issue position, and the tag of the read now returning.
  logic [ROW_AW-1:0]           scan_row_r;
  logic [WORD_AW-1:0]          scan_word_r;
  logic                        scan_done_r;   // last word already issued
  logic                        rd_pend_r;
  logic                        rd_last_r;
  logic [ROW_AW-1:0]           rd_row_r;
  logic [WORD_AW-1:0]          rd_word_r;

  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [FIELD_W-1:0]          out_found_col_r;
  logic [FIELD_W-1:0]          out_found_row_r;

  logic                        in_acc;
  logic                        pos_in_map;
  logic [MEM_AW-1:0]           bit_addr;
  logic [BIT_AW-1:0]           bit_sel;
  logic [WORD_W-1:0]           bit_mask;
  logic                        scan_last;
  logic [WORD_AW+BIT_AW-1:0]   found_col;

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc   = in_valid && in_ready;

  assign pos_in_map = (32'(col_r) < 32'(bmff_pkg::MAP_WIDTH)) &&
                      (32'(row_r) < 32'(bmff_pkg::MAP_HEIGHT));
  assign bit_addr   = {ROW_AW'(row_r), WORD_AW'(col_r >> BIT_AW)};
  assign bit_sel    = col_r[BIT_AW-1:0];
  assign bit_mask   = WORD_W'(1) << bit_sel;
  assign scan_last  = (scan_row_r == LAST_ROW) && (scan_word_r == LAST_WORD);
  assign found_col  = {rd_word_r, bmff_pkg::ffs32(rd_data_r)};

  // Memory port control: the clear sweep and write-back share the write side,
  // single-bit reads and the scan share the read side.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bit_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = bit_addr;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      ST_RD: begin
        mem_re = 1'b1;
      end
      ST_MOD: begin
        if (cmd_r == bmff_pkg::CMD_SET) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data_r | bit_mask;
        end else if (cmd_r == bmff_pkg::CMD_CLR) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data_r & ~bit_mask;
        end
      end
      ST_SCAN: begin
        mem_re    = !scan_done_r;
        mem_raddr = {scan_row_r, scan_word_r};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      scan_done_r <= 1'b0;
    end else begin
      // Drop the result once the far side has taken it.
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + MEM_AW'(1);
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= ST_IDLE;
            if (clr_reply_r) begin
              out_valid_r     <= 1'b1;
              out_hit_r       <= 1'b0;
              out_found_col_r <= '0;
              out_found_row_r <= '0;
            end
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_cmd;
            col_r <= in_col;
            row_r <= in_row;
            case (in_cmd)
              bmff_pkg::CMD_TEST,
              bmff_pkg::CMD_SET,
              bmff_pkg::CMD_CLR: begin
                // Range check happens on the held coordinates next cycle.
                state_r <= ST_RD;
              end
              bmff_pkg::CMD_CLRALL: begin
                clr_addr_r  <= '0;
                clr_reply_r <= 1'b1;
                state_r     <= ST_CLEAR;
              end
              bmff_pkg::CMD_FIND: begin
                scan_row_r  <= '0;
                scan_word_r <= '0;
                scan_done_r <= 1'b0;
                rd_pend_r   <= 1'b0;
                state_r     <= ST_SCAN;
              end
              default: begin
                out_valid_r     <= 1'b1;
                out_hit_r       <= 1'b0;
                out_found_col_r <= '0;
                out_found_row_r <= '0;
              end
            endcase
          end
        end

        ST_RD: begin
          if (pos_in_map) begin
            state_r <= ST_MOD;
          end else begin
            // Outside the map: answer zero, leave the store alone.
            out_valid_r     <= 1'b1;
            out_hit_r       <= 1'b0;
            out_found_col_r <= '0;
            out_found_row_r <= '0;
            state_r         <= ST_IDLE;
          end
        end

        ST_MOD: begin
          out_valid_r     <= 1'b1;
          out_hit_r       <= (cmd_r == bmff_pkg::CMD_TEST) && rd_data_r[bit_sel];
          out_found_col_r <= '0;
          out_found_row_r <= '0;
          state_r         <= ST_IDLE;
        end

        ST_SCAN: begin
          if (rd_pend_r && (rd_data_r != '0)) begin
            out_valid_r     <= 1'b1;
            out_hit_r       <= 1'b1;
            out_found_col_r <= FIELD_W'(found_col);
            out_found_row_r <= FIELD_W'(rd_row_r);
            rd_pend_r       <= 1'b0;
            state_r         <= ST_IDLE;
          end else if (rd_pend_r && rd_last_r) begin
            out_valid_r     <= 1'b1;
            out_hit_r       <= 1'b0;
            out_found_col_r <= '0;
            out_found_row_r <= '0;
            rd_pend_r       <= 1'b0;
            state_r         <= ST_IDLE;
          end else begin
            // Advance the scan: tag the word issued this cycle.
            rd_pend_r <= !scan_done_r;
            rd_last_r <= scan_last;
            rd_row_r  <= scan_row_r;
            rd_word_r <= scan_word_r;
            if (!scan_done_r) begin
              if (scan_last) begin
                scan_done_r <= 1'b1;
              end else if (scan_word_r == LAST_WORD) begin
                scan_word_r <= '0;
                scan_row_r  <= scan_row_r + ROW_AW'(1);
              end else begin
                scan_word_r <= scan_word_r + WORD_AW'(1);
              end
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_found_col = out_found_col_r;
  assign out_found_row = out_found_row_r;

  // The store is only written by the clear sweep or a set/clear write-back.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_CLEAR) || (state_r == ST_MOD)))
    else $error("memory written outside clear sweep or write-back");

  // A fresh result only ever comes out of a working state or an accepted word.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) != ST_IDLE) || $past(in_acc))
    else $error("result raised without an item in progress");

  // A non-zero scanned word must end the find with a hit.
  a_find_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && rd_pend_r && (rd_data_r != '0))
      |=> (out_valid_r && out_hit_r && (state_r == ST_IDLE)))
    else $error("find missed a non-zero word");

  // No new word while the previous result is still held.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !$past(in_acc) && !in_acc)
    else $error("word accepted while a result was pending");

endmodule

>>> tb/sv/bitmap_set_test_find_first_core_tb.sv
// Self-checking bench for bitmap_set_test_find_first_core: directed and random
// bit map commands, a shadow map that predicts each answer, and random stalls.
// Depends on bmff_pkg and the core RTL.
module bitmap_set_test_find_first_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_WIDTH     = bmff_pkg::MAP_WIDTH;
  localparam int MAP_HEIGHT    = bmff_pkg::MAP_HEIGHT;
  localparam int WORDS_PER_ROW = bmff_pkg::WORDS_PER_ROW;
  localparam int WORD_W        = bmff_pkg::WORD_W;
  localparam int BIT_AW        = bmff_pkg::BIT_AW;
  localparam int CMD_W         = bmff_pkg::CMD_W;
  localparam int FIELD_W       = bmff_pkg::FIELD_W;

  localparam int HALF_HI      = 6;
  localparam int HALF_LO      = 6;
  localparam int RESET_CYCLES = 11;
  localparam int MAP_WORDS    = MAP_HEIGHT * WORDS_PER_ROW;
  // A sweep or a full scan is the slowest single command; the clearing pass
  // after reset is as long. Leave generous room over either.
  localparam int STALL_LIMIT   = 4 * (bmff_pkg::MEM_DEPTH + 16);
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_WORDS  = 1426;
  localparam int DRAIN_EVERY   = 350;
  // Rows whose bits the generator keeps track of; finds that hit in here are cheap.
  localparam int LO_ROWS       = 16;
  localparam int PICK_DEPTH    = 64;
  localparam int LONG_BUDGET   = 10;
  localparam int MAX_GAP       = 6;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam logic [FIELD_W-1:0] FIELD_MAX      = '1;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] fcol;
    logic [FIELD_W-1:0] frow;
  } answer_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] row;
    bit                 drain;   // pause the sender until every answer is back
  } cmd_word_t;

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   in_cmd = bmff_pkg::CMD_TEST;
  logic [FIELD_W-1:0] in_col = '0;
  logic [FIELD_W-1:0] in_row = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_hit;
  logic [FIELD_W-1:0] out_found_col;
  logic [FIELD_W-1:0] out_found_row;

  bitmap_set_test_find_first_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_col        (in_col),
    .in_row        (in_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_found_col (out_found_col),
    .out_found_row (out_found_row)
  );

  always begin
    #(HALF_HI) clk = 1'b1;
    #(HALF_LO) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the bit map and the answers still owed by the core.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] map_words [MAP_WORDS];
  answer_t           answers_due [$];

  int n_words_in  = 0;
  int n_answers   = 0;
  int n_finds     = 0;
  int n_find_hits = 0;
  int n_sweeps    = 0;
  int n_errors    = 0;
  int stall_count = 0;

  // Apply one command to the shadow map and return the answer it owes.
  function automatic answer_t bitmap_apply(input logic [CMD_W-1:0] cmd,
                                           input logic [FIELD_W-1:0] col,
                                           input logic [FIELD_W-1:0] row);
    answer_t           ans;
    int                addr;
    int                b;
    logic [WORD_W-1:0] w;
    bit                on_map;
    ans    = '0;
    on_map = (int'(col) < MAP_WIDTH) && (int'(row) < MAP_HEIGHT);
    addr   = int'(row) * WORDS_PER_ROW + int'(col >> BIT_AW);
    case (cmd)
      bmff_pkg::CMD_TEST: begin
        if (on_map) ans.hit = map_words[addr][col[BIT_AW-1:0]];
      end
      bmff_pkg::CMD_SET: begin
        if (on_map) map_words[addr][col[BIT_AW-1:0]] = 1'b1;
      end
      bmff_pkg::CMD_CLR: begin
        if (on_map) map_words[addr][col[BIT_AW-1:0]] = 1'b0;
      end
      bmff_pkg::CMD_CLRALL: begin
        foreach (map_words[i]) map_words[i] = '0;
      end
      bmff_pkg::CMD_FIND: begin
        // Rows from the top, words from the left, bits from the lowest.
        addr = 0;
        while (addr < MAP_WORDS && map_words[addr] == '0) addr++;
        if (addr < MAP_WORDS) begin
          w = map_words[addr];
          b = 0;
          while (!w[b]) b++;
          ans.hit  = 1'b1;
          ans.fcol = FIELD_W'((addr % WORDS_PER_ROW) * WORD_W + b);
          ans.frow = FIELD_W'(addr / WORDS_PER_ROW);
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  initial foreach (map_words[i]) map_words[i] = '0;

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: check answers, predict accepted words, and
  // keep an eye on progress.
  // ---------------------------------------------------------------------------
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;

  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      // Check first: an answer leaving now belongs to an earlier word.
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        n_answers++;
        if (answers_due.size() == 0) begin
          n_errors++;
          $display("%0t: answer with none expected, hit %0d col %0d row %0d",
                   $time, out_hit, out_found_col, out_found_row);
        end else begin
          want = answers_due.pop_front();
          if (out_hit !== want.hit) begin
            n_errors++;
            $display("%0t: hit expected %0d, got %0d", $time, want.hit, out_hit);
          end
          if (out_found_col !== want.fcol) begin
            n_errors++;
            $display("%0t: found_col expected %0d, got %0d",
                     $time, want.fcol, out_found_col);
          end
          if (out_found_row !== want.frow) begin
            n_errors++;
            $display("%0t: found_row expected %0d, got %0d",
                     $time, want.frow, out_found_row);
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        n_words_in++;
        want = bitmap_apply(in_cmd, in_col, in_row);
        answers_due.insert(answers_due.size(), want);
        if (in_cmd == bmff_pkg::CMD_FIND) begin
          n_finds++;
          if (want.hit) n_find_hits++;
        end
        if (in_cmd == bmff_pkg::CMD_CLRALL) n_sweeps++;
      end
    end
    // Watchdog: count cycles in which neither channel moves a word.
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stall_count);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge, fed from the backlog.
  // ---------------------------------------------------------------------------
  cmd_word_t backlog [$];
  int        gap_left = 0;
  int        n_sent   = 0;

  always @(negedge clk) begin
    cmd_word_t nxt;
    bit        calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      // Every fourth stretch of 120 words goes without sender gaps.
      calm = ((n_sent / 120) % 4) == 2;
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (backlog[0].drain) begin
        // Hold off until the core has returned every answer.
        in_valid <= 1'b0;
        if (answers_due.size() == 0) void'(backlog.pop_front());
      end else begin
        nxt = backlog.pop_front();
        in_cmd   <= nxt.cmd;
        in_col   <= nxt.col;
        in_row   <= nxt.row;
        in_valid <= 1'b1;
        n_sent++;
        gap_left = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: draw a fresh wait for every answer taken.
  // ---------------------------------------------------------------------------
  int ready_wait = 0;

  always @(negedge clk) begin
    bit calm;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      calm = ((n_answers / 120) % 4) == 1;
      if (out_taken) begin
        out_taken  = 1'b0;
        ready_wait = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (ready_wait > 0) begin
        out_ready <= 1'b0;
        ready_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. The generator keeps a coarse record of the top rows so that
  // most finds stop early; sweeps and finds that must scan far are rationed.
  // ---------------------------------------------------------------------------
  logic [MAP_WIDTH-1:0] lo_rows [LO_ROWS];
  int                   pick_col [$];
  int                   pick_row [$];

  task automatic queue_word(input logic [CMD_W-1:0] cmd, input int cl, input int rw);
    cmd_word_t wd;
    wd.cmd   = cmd;
    wd.col   = FIELD_W'(cl);
    wd.row   = FIELD_W'(rw);
    wd.drain = 1'b0;
    backlog.insert(backlog.size(), wd);
    case (cmd)
      bmff_pkg::CMD_SET: begin
        if (rw < LO_ROWS) lo_rows[rw][cl] = 1'b1;
        pick_col.insert(pick_col.size(), cl);
        pick_row.insert(pick_row.size(), rw);
        if (pick_col.size() > PICK_DEPTH) begin
          void'(pick_col.pop_front());
          void'(pick_row.pop_front());
        end
      end
      bmff_pkg::CMD_CLR: begin
        if (rw < LO_ROWS) lo_rows[rw][cl] = 1'b0;
      end
      bmff_pkg::CMD_CLRALL: begin
        foreach (lo_rows[i]) lo_rows[i] = '0;
        pick_col.delete();
        pick_row.delete();
      end
      default: ;
    endcase
  endtask

  task automatic queue_drain();
    cmd_word_t wd;
    wd.cmd   = bmff_pkg::CMD_TEST;
    wd.col   = '0;
    wd.row   = '0;
    wd.drain = 1'b1;
    backlog.insert(backlog.size(), wd);
  endtask

  // First bit set in the tracked rows, if any.
  function automatic bit lowest_marked(output int cl, output int rw);
    cl = 0;
    rw = 0;
    for (int r = 0; r < LO_ROWS; r++) begin
      if (lo_rows[r] != '0) begin
        for (int c = 0; c < MAP_WIDTH; c++) begin
          if (lo_rows[r][c]) begin
            cl = c;
            rw = r;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  initial begin
    int sel;
    int cl;
    int rw;
    int k;
    int long_left;

    foreach (lo_rows[i]) lo_rows[i] = '0;
    long_left = LONG_BUDGET;

    // Directed: corners, every command, empty map, first-bit ordering inside
    // a word and across a word boundary, unused codes, alternating patterns.
    queue_word(bmff_pkg::CMD_TEST,   0,    0);       // fresh map reads zero
    queue_word(bmff_pkg::CMD_FIND,   0,    0);       // empty map: nothing found
    queue_word(bmff_pkg::CMD_SET,    1023, 1023);    // far corner
    queue_word(bmff_pkg::CMD_TEST,   1023, 1023);
    queue_word(bmff_pkg::CMD_FIND,   0,    0);       // full scan down to the last word
    queue_word(bmff_pkg::CMD_SET,    0,    0);
    queue_word(bmff_pkg::CMD_FIND,   0,    0);
    queue_word(bmff_pkg::CMD_SET,    31,   0);       // top bit of the first word
    queue_word(bmff_pkg::CMD_SET,    32,   0);       // bottom bit of the second word
    queue_word(bmff_pkg::CMD_CLR,    0,    0);
    queue_word(bmff_pkg::CMD_FIND,   0,    0);
    queue_word(bmff_pkg::CMD_CLR,    31,   0);
    queue_word(bmff_pkg::CMD_FIND,   0,    0);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      queue_word(CMD_W'(c), FIELD_MAX, FIELD_MAX);
    queue_word(bmff_pkg::CMD_TEST,   32,    0);      // untouched by the unused codes
    queue_word(bmff_pkg::CMD_SET,    'h2AA, 'h155);
    queue_word(bmff_pkg::CMD_TEST,   'h155, 'h2AA);
    queue_word(bmff_pkg::CMD_TEST,   'h2AA, 'h155);
    queue_word(bmff_pkg::CMD_CLRALL, FIELD_MAX, FIELD_MAX);
    queue_word(bmff_pkg::CMD_TEST,   1023, 1023);
    queue_word(bmff_pkg::CMD_TEST,   32,   0);
    queue_word(bmff_pkg::CMD_CLR,    'h155, 'h2AA);  // clearing a bit already clear
    queue_drain();

    // Random: mostly work in the top rows so finds land early and move as
    // their leading bits are cleared; now and then touch the whole map.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) queue_drain();
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        queue_word(bmff_pkg::CMD_SET, $urandom_range(0, MAP_WIDTH - 1),
                   $urandom_range(0, LO_ROWS - 1));
      end else if (sel < 34) begin
        queue_word(bmff_pkg::CMD_SET, $urandom_range(0, MAP_WIDTH - 1),
                   $urandom_range(0, MAP_HEIGHT - 1));
      end else if (sel < 52) begin
        // Drop a known bit, the current leader, or somewhere at random.
        k = $urandom_range(0, 9);
        if (k < 3 && lowest_marked(cl, rw)) begin
          queue_word(bmff_pkg::CMD_CLR, cl, rw);
        end else if (k < 8 && pick_col.size() != 0) begin
          k = $urandom_range(0, pick_col.size() - 1);
          queue_word(bmff_pkg::CMD_CLR, pick_col[k], pick_row[k]);
        end else begin
          queue_word(bmff_pkg::CMD_CLR, $urandom_range(0, MAP_WIDTH - 1),
                     $urandom_range(0, MAP_HEIGHT - 1));
        end
      end else if (sel < 70) begin
        if ($urandom_range(0, 1) && pick_col.size() != 0) begin
          k = $urandom_range(0, pick_col.size() - 1);
          queue_word(bmff_pkg::CMD_TEST, pick_col[k], pick_row[k]);
        end else begin
          queue_word(bmff_pkg::CMD_TEST, $urandom_range(0, MAP_WIDTH - 1),
                     $urandom_range(0, MAP_HEIGHT - 1));
        end
      end else if (sel < 90) begin
        if (lowest_marked(cl, rw)) begin
          queue_word(bmff_pkg::CMD_FIND, $urandom_range(0, MAP_WIDTH - 1),
                     $urandom_range(0, MAP_HEIGHT - 1));
        end else if (long_left > 0) begin
          long_left--;
          queue_word(bmff_pkg::CMD_FIND, $urandom_range(0, MAP_WIDTH - 1),
                     $urandom_range(0, MAP_HEIGHT - 1));
        end else begin
          queue_word(bmff_pkg::CMD_SET, $urandom_range(0, MAP_WIDTH - 1),
                     $urandom_range(0, LO_ROWS - 1));
        end
      end else if (sel < 95) begin
        queue_word(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                   $urandom_range(0, MAP_WIDTH - 1), $urandom_range(0, MAP_HEIGHT - 1));
      end else if (sel < 97 && long_left > 0) begin
        long_left--;
        queue_word(bmff_pkg::CMD_CLRALL, $urandom_range(0, MAP_WIDTH - 1),
                   $urandom_range(0, MAP_HEIGHT - 1));
      end else begin
        queue_word(bmff_pkg::CMD_TEST, $urandom_range(0, MAP_WIDTH - 1),
                   $urandom_range(0, MAP_HEIGHT - 1));
      end
    end

    // Release reset after the hold period, at a falling edge.
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the backlog to go, then for the last answer, then let it settle.
    while (backlog.size() != 0 || in_valid) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d commands and checked %0d answers on the bit map,",
             n_words_in, n_answers);
    $display("including %0d finds (%0d with a set bit) and %0d full sweeps.",
             n_finds, n_find_hits, n_sweeps);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/bmff_pkg.sv
rtl/core/bitmap_set_test_find_first_core.sv
tb/sv/bitmap_set_test_find_first_core_tb.sv
